// ===== hw/rtl/ksv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_pkg
// Shared types, constants and rounding helpers of the kidney surface
// evaluator.
// ----------------------------------------------------------------------------
package ksv_pkg;

	localparam int unsigned LANES      = 3;   // u, v, 3v
	localparam int unsigned TERMS      = 7;   // series correction terms
	localparam int unsigned OUT_W      = 22;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	localparam logic signed [55:0] OUT_MAX = 56'sd2097151;
	localparam logic signed [55:0] OUT_MIN = -56'sd2097152;

	typedef enum logic [2:0] {
		KIND_POS = 3'd0,
		KIND_DU  = 3'd1,
		KIND_DV  = 3'd2,
		KIND_NRM = 3'd3,
		KIND_DUU = 3'd4,
		KIND_DUV = 3'd5,
		KIND_DVV = 3'd6
	} ksv_kind_t;

	// one angle lane in flight through the series chain
	typedef struct packed {
		logic [30:0]        ts;
		logic [30:0]        tc;
		logic signed [33:0] ss;
		logic signed [33:0] sc;
		logic [31:0]        x2;
		logic [1:0]         quad;
	} ksv_lane_t;

	typedef struct packed {
		logic                        valid;
		ksv_lane_t [LANES-1:0]       lane;
	} ksv_chain_t;

	// scalar factors of one input, Q24 unless noted
	typedef struct packed {
		logic signed [25:0] cu;
		logic signed [25:0] su;
		logic signed [30:0] f;
		logic signed [30:0] vf;
		logic signed [30:0] wf;
		logic signed [30:0] nf;
		logic signed [30:0] zp;
		logic signed [30:0] zv;
		logic signed [30:0] zw;
		logic signed [55:0] zn;   // Q48
	} ksv_item_t;

	// round to nearest, ties away from zero
	function automatic logic signed [55:0] ksv_round_shift(input logic signed [55:0] v,
		input int unsigned s);
		logic [55:0] mag;
		logic [55:0] r;
		mag = v[55] ? 56'(-v) : 56'(v);
		r = (mag + (56'd1 << (s - 1))) >> s;
		return v[55] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [OUT_W-1:0] ksv_to_out(input logic signed [55:0] v,
		input int unsigned s);
		logic signed [55:0] r;
		r = ksv_round_shift(v, s);
		if (r > OUT_MAX)
			r = OUT_MAX;
		else if (r < OUT_MIN)
			r = OUT_MIN;
		return r[OUT_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/ksv_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_in_if
// Angle word channel: u and v surface parameters.
// ----------------------------------------------------------------------------
interface ksv_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        u_angle;
	logic signed [15:0] v_angle;

	modport source(output valid, output u_angle, output v_angle, input ready);
	modport sink(input valid, input u_angle, input v_angle, output ready);
endinterface

// ===== hw/rtl/ksv_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_out_if
// Vector word channel: one surface vector per word.
// ----------------------------------------------------------------------------
interface ksv_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         vector_kind;
	logic signed [21:0] x_component;
	logic signed [21:0] y_component;
	logic signed [21:0] z_component;
	logic               last_vector;

	modport source(output valid, output vector_kind, output x_component,
		output y_component, output z_component, output last_vector, input ready);
	modport sink(input valid, input vector_kind, input x_component,
		input y_component, input z_component, input last_vector, output ready);
endinterface

// ===== hw/rtl/ksv_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_phase
// Turns u, v and 3v into quadrant, x = r * pi/2 and x^2, all Q30.
// ----------------------------------------------------------------------------
module ksv_phase #(
	parameter int unsigned ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [15:0]        u_angle,
	input  logic signed [15:0] v_angle,
	output ksv_pkg::ksv_chain_t d_out
);
	localparam int unsigned SH = 32 - ANGLE_BITS;

	logic [31:0] ph [ksv_pkg::LANES];
	logic [63:0] xr [ksv_pkg::LANES];
	logic [63:0] sq [ksv_pkg::LANES];
	logic [30:0] x_s1 [ksv_pkg::LANES];
	logic [1:0]  quad_s1 [ksv_pkg::LANES];
	logic        valid_s1;
	logic        valid_s2;
	ksv_pkg::ksv_lane_t [ksv_pkg::LANES-1:0] lane_s2;

	always_comb begin
		ph[0] = {16'd0, u_angle} << SH;
		ph[1] = {{16{v_angle[15]}}, v_angle} << SH;
		ph[2] = ph[1] + {ph[1][30:0], 1'b0};
		for (int l = 0; l < ksv_pkg::LANES; l++) begin
			xr[l] = 64'(ph[l][29:0]) * 64'(ksv_pkg::HALF_PI_Q30) + (64'd1 << 29);
			sq[l] = 64'(x_s1[l]) * 64'(x_s1[l]) + (64'd1 << 29);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ksv_pkg::LANES; l++) begin
				x_s1[l] <= xr[l][60:30];
				quad_s1[l] <= ph[l][31:30];
				lane_s2[l].ts <= x_s1[l];
				lane_s2[l].tc <= 31'(ksv_pkg::ONE_Q30);
				lane_s2[l].ss <= $signed({3'b000, x_s1[l]});
				lane_s2[l].sc <= ksv_pkg::ONE_Q30;
				lane_s2[l].x2 <= sq[l][61:30];
				lane_s2[l].quad <= quad_s1[l];
			end
		end
	end

	assign d_out = {valid_s2, lane_s2};
endmodule

// ===== hw/rtl/ksv_term_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_term_cell
// One Taylor step for sin and cos of every lane: term * x^2, divide by the
// series integer, add into the running sums. Three stages.
// ----------------------------------------------------------------------------
module ksv_term_cell #(
	parameter int unsigned K = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ksv_pkg::ksv_chain_t d_in,
	output ksv_pkg::ksv_chain_t d_out
);
	localparam int unsigned DS = 2 * K * (2 * K + 1);
	localparam int unsigned DC = (2 * K - 1) * 2 * K;
	localparam longint unsigned MS_L = (64'd1 << 32) / DS;
	localparam longint unsigned MC_L = (64'd1 << 32) / DC;
	localparam logic [31:0] MS = 32'(MS_L);
	localparam logic [31:0] MC = 32'(MC_L);
	localparam bit SUB = (K % 2) == 1;

	typedef struct packed {
		logic [32:0]        ps;
		logic [32:0]        pc;
		logic signed [33:0] ss;
		logic signed [33:0] sc;
		logic [31:0]        x2;
		logic [1:0]         quad;
	} mul_t;

	typedef struct packed {
		logic [33:0]        ns;
		logic [33:0]        nc;
		logic [31:0]        qs;
		logic [31:0]        qc;
		logic signed [33:0] ss;
		logic signed [33:0] sc;
		logic [31:0]        x2;
		logic [1:0]         quad;
	} quo_t;

	mul_t [ksv_pkg::LANES-1:0] m_s1;
	quo_t [ksv_pkg::LANES-1:0] q_s2;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	ksv_pkg::ksv_lane_t [ksv_pkg::LANES-1:0] lane_s3;

	logic [63:0] prs [ksv_pkg::LANES];
	logic [63:0] prc [ksv_pkg::LANES];
	logic [33:0] ns  [ksv_pkg::LANES];
	logic [33:0] nc  [ksv_pkg::LANES];
	logic [65:0] qms [ksv_pkg::LANES];
	logic [65:0] qmc [ksv_pkg::LANES];
	logic [33:0] rfs [ksv_pkg::LANES];
	logic [33:0] rfc [ksv_pkg::LANES];
	logic [2:0]  cs  [ksv_pkg::LANES];
	logic [2:0]  cc  [ksv_pkg::LANES];
	logic [31:0] ts  [ksv_pkg::LANES];
	logic [31:0] tc  [ksv_pkg::LANES];

	always_comb begin
		for (int l = 0; l < ksv_pkg::LANES; l++) begin
			prs[l] = 64'(d_in.lane[l].ts) * 64'(d_in.lane[l].x2) + (64'd1 << 29);
			prc[l] = 64'(d_in.lane[l].tc) * 64'(d_in.lane[l].x2) + (64'd1 << 29);
			// rounding offset, then reciprocal estimate (at most four short)
			ns[l] = {1'b0, m_s1[l].ps} + 34'(DS / 2);
			nc[l] = {1'b0, m_s1[l].pc} + 34'(DC / 2);
			qms[l] = {32'd0, ns[l]} * {34'd0, MS};
			qmc[l] = {32'd0, nc[l]} * {34'd0, MC};
			// fix up the estimate from the remainder
			rfs[l] = q_s2[l].ns - 34'({2'b00, q_s2[l].qs} * 34'(DS));
			rfc[l] = q_s2[l].nc - 34'({2'b00, q_s2[l].qc} * 34'(DC));
			cs[l] = 3'(rfs[l][10:0] >= 11'(DS)) + 3'(rfs[l][10:0] >= 11'(2 * DS))
				+ 3'(rfs[l][10:0] >= 11'(3 * DS)) + 3'(rfs[l][10:0] >= 11'(4 * DS));
			cc[l] = 3'(rfc[l][10:0] >= 11'(DC)) + 3'(rfc[l][10:0] >= 11'(2 * DC))
				+ 3'(rfc[l][10:0] >= 11'(3 * DC)) + 3'(rfc[l][10:0] >= 11'(4 * DC));
			ts[l] = q_s2[l].qs + 32'(cs[l]);
			tc[l] = q_s2[l].qc + 32'(cc[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ksv_pkg::LANES; l++) begin
				m_s1[l].ps <= prs[l][62:30];
				m_s1[l].pc <= prc[l][62:30];
				m_s1[l].ss <= d_in.lane[l].ss;
				m_s1[l].sc <= d_in.lane[l].sc;
				m_s1[l].x2 <= d_in.lane[l].x2;
				m_s1[l].quad <= d_in.lane[l].quad;

				q_s2[l].ns <= ns[l];
				q_s2[l].nc <= nc[l];
				q_s2[l].qs <= qms[l][63:32];
				q_s2[l].qc <= qmc[l][63:32];
				q_s2[l].ss <= m_s1[l].ss;
				q_s2[l].sc <= m_s1[l].sc;
				q_s2[l].x2 <= m_s1[l].x2;
				q_s2[l].quad <= m_s1[l].quad;

				lane_s3[l].ts <= ts[l][30:0];
				lane_s3[l].tc <= tc[l][30:0];
				if (SUB) begin
					lane_s3[l].ss <= q_s2[l].ss - $signed({3'b000, ts[l][30:0]});
					lane_s3[l].sc <= q_s2[l].sc - $signed({3'b000, tc[l][30:0]});
				end else begin
					lane_s3[l].ss <= q_s2[l].ss + $signed({3'b000, ts[l][30:0]});
					lane_s3[l].sc <= q_s2[l].sc + $signed({3'b000, tc[l][30:0]});
				end
				lane_s3[l].x2 <= q_s2[l].x2;
				lane_s3[l].quad <= q_s2[l].quad;
			end
		end
	end

	assign d_out = {valid_s3, lane_s3};
endmodule

// ===== hw/rtl/ksv_factor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_factor
// Clamps and turns the series sums by quadrant, rounds to Q24 and forms the
// scalar factors shared by the seven vectors. Three stages.
// ----------------------------------------------------------------------------
module ksv_factor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ksv_pkg::ksv_chain_t d_in,
	output logic                out_valid,
	output ksv_pkg::ksv_item_t  item
);
	logic [30:0]        s0 [ksv_pkg::LANES];
	logic [30:0]        c0 [ksv_pkg::LANES];
	logic signed [25:0] rs [ksv_pkg::LANES];
	logic signed [25:0] rc [ksv_pkg::LANES];
	logic signed [25:0] sn_s1 [ksv_pkg::LANES];
	logic signed [25:0] cs_s1 [ksv_pkg::LANES];
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;

	logic signed [25:0] cu, su, sv, cv, s3, c3;
	logic signed [30:0] f_w, vf_w, wf_w, zp_w, zv_w, zw_w;
	logic signed [51:0] pcc, pc3, p33, pcs, pcs3, p3s3, p3s;

	logic signed [25:0] cu_s2, su_s2;
	logic signed [30:0] f_s2, vf_s2, wf_s2, zp_s2, zv_s2, zw_s2;
	logic signed [51:0] pcc_s2, pc3_s2, p33_s2, pcs_s2, pcs3_s2, p3s3_s2, p3s_s2;
	logic signed [55:0] nsum;
	logic signed [55:0] nr;
	logic signed [55:0] zn_w;
	ksv_pkg::ksv_item_t item_s3;

	always_comb begin
		for (int l = 0; l < ksv_pkg::LANES; l++) begin
			if (d_in.lane[l].ss < 0)
				s0[l] = '0;
			else if (d_in.lane[l].ss > ksv_pkg::ONE_Q30)
				s0[l] = 31'(ksv_pkg::ONE_Q30);
			else
				s0[l] = d_in.lane[l].ss[30:0];
			if (d_in.lane[l].sc < 0)
				c0[l] = '0;
			else if (d_in.lane[l].sc > ksv_pkg::ONE_Q30)
				c0[l] = 31'(ksv_pkg::ONE_Q30);
			else
				c0[l] = d_in.lane[l].sc[30:0];
			rs[l] = $signed({1'b0, 25'((32'(s0[l]) + 32'd32) >> 6)});
			rc[l] = $signed({1'b0, 25'((32'(c0[l]) + 32'd32) >> 6)});
		end
	end

	assign cu = cs_s1[0];
	assign su = sn_s1[0];
	assign cv = cs_s1[1];
	assign sv = sn_s1[1];
	assign c3 = cs_s1[2];
	assign s3 = sn_s1[2];

	assign f_w  = 31'sd3 * cv - c3;
	assign vf_w = 31'sd3 * s3 - 31'sd3 * sv;
	assign wf_w = 31'sd9 * c3 - 31'sd3 * cv;
	assign zp_w = 31'sd3 * sv - s3;
	assign zv_w = 31'sd3 * cv - 31'sd3 * c3;
	assign zw_w = 31'sd9 * s3 - 31'sd3 * sv;

	assign pcc  = cv * cv;
	assign pc3  = cv * c3;
	assign p33  = c3 * c3;
	assign pcs  = cv * sv;
	assign pcs3 = cv * s3;
	assign p3s3 = c3 * s3;
	assign p3s  = c3 * sv;

	assign nsum = 56'sd9 * pcc_s2 - 56'sd12 * pc3_s2 + 56'sd3 * p33_s2;
	assign nr   = ksv_pkg::ksv_round_shift(nsum, 24);
	assign zn_w = 56'sd9 * (pcs_s2 - pcs3_s2) + 56'sd3 * (p3s3_s2 - p3s_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ksv_pkg::LANES; l++) begin
				unique case (d_in.lane[l].quad)
					2'd0: begin
						sn_s1[l] <= rs[l];
						cs_s1[l] <= rc[l];
					end
					2'd1: begin
						sn_s1[l] <= rc[l];
						cs_s1[l] <= -rs[l];
					end
					2'd2: begin
						sn_s1[l] <= -rs[l];
						cs_s1[l] <= -rc[l];
					end
					default: begin
						sn_s1[l] <= -rc[l];
						cs_s1[l] <= rs[l];
					end
				endcase
			end

			cu_s2 <= cu;
			su_s2 <= su;
			f_s2 <= f_w;
			vf_s2 <= vf_w;
			wf_s2 <= wf_w;
			zp_s2 <= zp_w;
			zv_s2 <= zv_w;
			zw_s2 <= zw_w;
			pcc_s2 <= pcc;
			pc3_s2 <= pc3;
			p33_s2 <= p33;
			pcs_s2 <= pcs;
			pcs3_s2 <= pcs3;
			p3s3_s2 <= p3s3;
			p3s_s2 <= p3s;

			item_s3.cu <= cu_s2;
			item_s3.su <= su_s2;
			item_s3.f <= f_s2;
			item_s3.vf <= vf_s2;
			item_s3.wf <= wf_s2;
			item_s3.nf <= nr[30:0];
			item_s3.zp <= zp_s2;
			item_s3.zv <= zv_s2;
			item_s3.zw <= zw_s2;
			item_s3.zn <= zn_w;
		end
	end

	assign out_valid = valid_s3;
	assign item = item_s3;
endmodule

// ===== hw/rtl/ksv_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksv_emit
// Holds one item's factors and sends its seven vectors, one word a cycle
// while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module ksv_emit #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ksv_pkg::ksv_item_t item,
	output logic               in_ready,
	ksv_out_if.source          vector_out
);
	localparam int unsigned OSH = 48 - FRAC_BITS;

	ksv_pkg::ksv_item_t  item_q;
	ksv_pkg::ksv_kind_t  kind_q;
	logic                busy_q;
	logic                out_valid_q;
	logic [2:0]          out_kind_q;
	logic signed [21:0]  out_x_q, out_y_q, out_z_q;
	logic                out_last_q;

	logic                load_out;
	logic                take;
	logic signed [25:0]  a_sel, b_sel;
	logic signed [30:0]  fac;
	logic signed [55:0]  z_sel;
	logic signed [55:0]  mx, my;

	assign load_out = !out_valid_q || vector_out.ready;
	assign in_ready = !busy_q || (load_out && kind_q == ksv_pkg::KIND_DVV);
	assign take = in_valid && in_ready;

	always_comb begin
		unique case (kind_q)
			ksv_pkg::KIND_POS: begin
				a_sel = item_q.cu;
				b_sel = item_q.su;
				fac = item_q.f;
				z_sel = 56'(item_q.zp) <<< 24;
			end
			ksv_pkg::KIND_DU: begin
				a_sel = -item_q.su;
				b_sel = item_q.cu;
				fac = item_q.f;
				z_sel = '0;
			end
			ksv_pkg::KIND_DV: begin
				a_sel = item_q.cu;
				b_sel = item_q.su;
				fac = item_q.vf;
				z_sel = 56'(item_q.zv) <<< 24;
			end
			ksv_pkg::KIND_NRM: begin
				a_sel = item_q.cu;
				b_sel = item_q.su;
				fac = item_q.nf;
				z_sel = item_q.zn;
			end
			ksv_pkg::KIND_DUU: begin
				a_sel = -item_q.cu;
				b_sel = -item_q.su;
				fac = item_q.f;
				z_sel = '0;
			end
			ksv_pkg::KIND_DUV: begin
				a_sel = -item_q.su;
				b_sel = item_q.cu;
				fac = item_q.vf;
				z_sel = '0;
			end
			ksv_pkg::KIND_DVV: begin
				a_sel = item_q.cu;
				b_sel = item_q.su;
				fac = item_q.wf;
				z_sel = 56'(item_q.zw) <<< 24;
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
				fac = '0;
				z_sel = '0;
			end
		endcase
	end

	assign mx = a_sel * fac;
	assign my = b_sel * fac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= ksv_pkg::KIND_POS;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= busy_q;
			if (take) begin
				busy_q <= 1'b1;
				kind_q <= ksv_pkg::KIND_POS;
			end else if (load_out && busy_q) begin
				if (kind_q == ksv_pkg::KIND_DVV)
					busy_q <= 1'b0;
				kind_q <= ksv_pkg::ksv_kind_t'(kind_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_q <= item;
		if (load_out && busy_q) begin
			out_kind_q <= kind_q;
			out_x_q <= ksv_pkg::ksv_to_out(mx, OSH);
			out_y_q <= ksv_pkg::ksv_to_out(my, OSH);
			out_z_q <= ksv_pkg::ksv_to_out(z_sel, OSH);
			out_last_q <= kind_q == ksv_pkg::KIND_DVV;
		end
	end

	assign vector_out.valid = out_valid_q;
	assign vector_out.vector_kind = out_kind_q;
	assign vector_out.x_component = out_x_q;
	assign vector_out.y_component = out_y_q;
	assign vector_out.z_component = out_z_q;
	assign vector_out.last_vector = out_last_q;
endmodule

// ===== hw/rtl/kidney_surface_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kidney_surface_evaluator_core
// Kidney surface point, normal and derivatives from angles u and v.
//
//   channel     dir  word
//   angle_in    in   u_angle[15:0], v_angle[15:0] signed
//   vector_out  out  vector_kind[2:0], x/y/z_component[21:0] signed Q5.16,
//                    last_vector
//
// Each angle word yields seven vector words, one per cycle through the
// output register while the receiver is ready; the single vector output
// port limits the angle word rate. While a word is sent, a new angle word
// enters the chain of seven series cells each cycle, but the chain stalls
// as a whole when its last stage holds an item the sender cannot yet take.
// The first vector passes the phase, series and factor stages, the item
// register and output register. Reset clears only valid and control flops.
// ----------------------------------------------------------------------------
module kidney_surface_evaluator_core #(
	parameter int unsigned ANGLE_BITS = 16,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ksv_in_if.sink    angle_in,
	ksv_out_if.source vector_out
);
	logic                en;
	logic                fac_valid;
	logic                emit_ready;
	ksv_pkg::ksv_item_t  fac_item;
	ksv_pkg::ksv_chain_t chain [ksv_pkg::TERMS + 1];

	// advance the whole chain unless its last item has nowhere to go
	assign en = !fac_valid || emit_ready;
	assign angle_in.ready = en;

	ksv_phase #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(angle_in.valid),
		.u_angle (angle_in.u_angle),
		.v_angle (angle_in.v_angle),
		.d_out   (chain[0])
	);

	for (genvar gi = 1; gi <= ksv_pkg::TERMS; gi++) begin : g_cell
		ksv_term_cell #(
			.K(gi)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d_in  (chain[gi-1]),
			.d_out (chain[gi])
		);
	end

	ksv_factor u_factor (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.d_in     (chain[ksv_pkg::TERMS]),
		.out_valid(fac_valid),
		.item     (fac_item)
	);

	ksv_emit #(
		.FRAC_BITS(FRAC_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fac_valid),
		.item      (fac_item),
		.in_ready  (emit_ready),
		.vector_out(vector_out)
	);

`ifndef NO_ASSERTIONS
	a_last_marks_dvv: assert property (@(posedge clk) disable iff (!arst_n)
		vector_out.valid |->
			(vector_out.last_vector == (vector_out.vector_kind == ksv_pkg::KIND_DVV)))
		else $error("last_vector does not match the final vector kind");

	a_kind_order: assert property (@(posedge clk) disable iff (!arst_n)
		vector_out.valid && vector_out.ready && !vector_out.last_vector |=>
			vector_out.valid &&
			vector_out.vector_kind == 3'($past(vector_out.vector_kind) + 3'd1))
		else $error("vector words of one item are not sent back to back in order");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fac_valid && !emit_ready |=> fac_valid)
		else $error("finished item dropped while the sender was busy");
`endif
endmodule

// ===== tb/sv/tb_kidney_surface_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kidney_surface_evaluator_core
// Drives angle words into the kidney surface evaluator and checks each of
// the seven vector words per angle word against a local fixed-point model.
// Runs directed corners, then random angles under several idling phases.
// ----------------------------------------------------------------------------
module tb_kidney_surface_evaluator_core;

	typedef struct packed {
		ksv_pkg::ksv_kind_t kind;
		logic signed [21:0] x;
		logic signed [21:0] y;
		logic signed [21:0] z;
		logic               last;
	} vec_word_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	ksv_in_if  angle_in();
	ksv_out_if vector_out();

	vec_word_t expected_vectors[$];
	int        mismatch_count;
	int        idle_cycles;
	int        send_idle_pct;
	int        stall_pct;

	kidney_surface_evaluator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.angle_in(angle_in),
		.vector_out(vector_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint round_half_away(input longint v, input int s);
		longint unsigned mag;
		longint unsigned r;
		mag = v < 0 ? longint'(-v) : longint'(v);
		r = (mag + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	// sin and cos of a 32-bit turn phase, Q24
	task automatic phase_sincos(input logic [31:0] p, output longint sn, output longint cs);
		longint unsigned x, x2, ts, tc, ds, dc;
		longint ss, sc, s0, c0;
		x = ({32'd0, 2'b00, p[29:0]} * 64'd1686629713 + (64'd1 << 29)) >> 30;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		ss = x;
		sc = 64'd1 << 30;
		for (int k = 1; k <= 7; k++) begin
			ds = (2 * k) * (2 * k + 1);
			dc = (2 * k - 1) * (2 * k);
			ts = (ts * x2 + (64'd1 << 29)) >> 30;
			ts = (ts + ds / 2) / ds;
			tc = (tc * x2 + (64'd1 << 29)) >> 30;
			tc = (tc + dc / 2) / dc;
			if (k % 2) begin
				ss -= ts;
				sc -= tc;
			end else begin
				ss += ts;
				sc += tc;
			end
		end
		s0 = ss < 0 ? 0 : (ss > (64'd1 << 30) ? (64'd1 << 30) : ss);
		c0 = sc < 0 ? 0 : (sc > (64'd1 << 30) ? (64'd1 << 30) : sc);
		case (p[31:30])
			2'd0: begin sn = s0;  cs = c0;  end
			2'd1: begin sn = c0;  cs = -s0; end
			2'd2: begin sn = -s0; cs = -c0; end
			default: begin sn = -c0; cs = s0; end
		endcase
		sn = round_half_away(sn, 6);
		cs = round_half_away(cs, 6);
	endtask

	function automatic logic signed [21:0] q48_to_component(input longint v);
		longint r;
		r = round_half_away(v, 32);
		if (r > 2097151)
			r = 2097151;
		if (r < -2097152)
			r = -2097152;
		return r[21:0];
	endfunction

	function automatic vec_word_t make_vector(input ksv_pkg::ksv_kind_t kind, input longint x,
		input longint y, input longint z);
		vec_word_t w;
		w.kind = kind;
		w.x = q48_to_component(x);
		w.y = q48_to_component(y);
		w.z = q48_to_component(z);
		w.last = (kind == ksv_pkg::KIND_DVV);
		return w;
	endfunction

	task automatic predict_surface(input logic [15:0] u, input logic [15:0] v);
		logic [31:0] pu, pv, p3;
		longint su, cu, sv, cv, s3, c3, f, vf, wf, nf, one;
		one = 64'd1 << 24;
		pu = {u, 16'd0};
		pv = {v, 16'd0};
		p3 = pv * 32'd3;
		phase_sincos(pu, su, cu);
		phase_sincos(pv, sv, cv);
		phase_sincos(p3, s3, c3);
		f = 3 * cv - c3;
		vf = 3 * s3 - 3 * sv;
		wf = 9 * c3 - 3 * cv;
		nf = round_half_away(9 * cv * cv - 12 * cv * c3 + 3 * c3 * c3, 24);
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_POS, cu * f, su * f,
			(3 * sv - s3) * one));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_DU, -su * f, cu * f, 0));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_DV, cu * vf, su * vf,
			(3 * cv - 3 * c3) * one));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_NRM, cu * nf, su * nf,
			9 * (cv * sv - cv * s3) + 3 * (c3 * s3 - c3 * sv)));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_DUU, -cu * f, -su * f, 0));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_DUV, -su * vf, cu * vf, 0));
		expected_vectors.push_back(make_vector(ksv_pkg::KIND_DVV, cu * wf, su * wf,
			(9 * s3 - 3 * sv) * one));
	endtask

	// valid stays high after an accept unless the sender idles or drains
	task automatic send_angles(input logic [15:0] u, input logic [15:0] v);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			angle_in.valid <= 1'b0;
			@(posedge clk);
		end
		angle_in.valid <= 1'b1;
		angle_in.u_angle <= u;
		angle_in.v_angle <= v;
		predict_surface(u, v);
		do
			@(posedge clk);
		while (!angle_in.ready);
	endtask

	task automatic drain;
		angle_in.valid <= 1'b0;
		while (expected_vectors.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic test_corner_angles;
		logic [15:0] corners[12] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h4000,
			16'hC000, 16'h2000, 16'h5555, 16'hAAAA, 16'h0001, 16'h2AAB, 16'h1555};
		send_idle_pct = 0;
		stall_pct = 0;
		foreach (corners[i])
			send_angles(corners[i], corners[(i + 5) % 12]);
		send_angles(16'h0000, 16'h0000);
		send_angles(16'hFFFF, 16'h8000);
		send_angles(16'h8000, 16'h7FFF);
		drain();
	endtask

	task automatic test_random_angles(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n)
			send_angles(16'($urandom), 16'($urandom));
		drain();
	endtask

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_out.ready <= 1'b0;
		end else begin
			vector_out.ready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		vec_word_t exp_w;
		if (arst_n && vector_out.valid && vector_out.ready) begin
			if (expected_vectors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected vector word kind %0d", vector_out.vector_kind);
			end else begin
				exp_w = expected_vectors.pop_front();
				if (vector_out.vector_kind !== exp_w.kind || vector_out.x_component !== exp_w.x
					|| vector_out.y_component !== exp_w.y
					|| vector_out.z_component !== exp_w.z
					|| vector_out.last_vector !== exp_w.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch exp k%0d %0d %0d %0d l%0d got k%0d %0d %0d %0d l%0d",
							exp_w.kind, exp_w.x, exp_w.y, exp_w.z, exp_w.last,
							vector_out.vector_kind, vector_out.x_component,
							vector_out.y_component, vector_out.z_component,
							vector_out.last_vector);
				end
			end
		end
	end

	// watchdog: count cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((angle_in.valid && angle_in.ready) || (vector_out.valid && vector_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		angle_in.valid = 1'b0;
		angle_in.u_angle = '0;
		angle_in.v_angle = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_angles();
		test_random_angles(40, 0, 0);
		test_random_angles(35, 88, 0);
		test_random_angles(35, 0, 88);
		test_random_angles(40, 23, 23);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== kidney_surface_evaluator_core.f =====
hw/rtl/ksv_pkg.sv
hw/rtl/ksv_in_if.sv
hw/rtl/ksv_out_if.sv
hw/rtl/ksv_phase.sv
hw/rtl/ksv_term_cell.sv
hw/rtl/ksv_factor.sv
hw/rtl/ksv_emit.sv
hw/rtl/kidney_surface_evaluator_core.sv
tb/sv/tb_kidney_surface_evaluator_core.sv
